// File: rtl/o1_priority_run_queue_assert.svh
// ----------------------------------------------------------------------------
// O(1) run queue assertion macros
// Assertion helpers for the run queue. Every check uses i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef O1_PRIORITY_RUN_QUEUE_ASSERT_SVH
`define O1_PRIORITY_RUN_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define O1RQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("o1 run queue check failed");
`define O1RQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("o1 run queue check failed");
`else
`define O1RQ_ASSERT_NOW(lbl, ante, cons)
`define O1RQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/o1rq_pkg.sv
// ----------------------------------------------------------------------------
// O(1) run queue package
// Shared types for the controller and the datapath of the run queue.
// ----------------------------------------------------------------------------
`default_nettype none
package o1rq_pkg;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_RESCHED = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS1 = 8'b0000_0010,
        S_INS2 = 8'b0000_0100,
        S_RS1  = 8'b0000_1000,
        S_RS2  = 8'b0001_0000,
        S_RS3  = 8'b0010_0000,
        S_RS4  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // One step enable per sequencer state.
    typedef struct packed {
        logic accept;
        logic ins_append;
        logic ins_link;
        logic rs_append;
        logic rs_pick;
        logic rs_take;
        logic rs_head;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_ins_ok;
        logic in_resched;
        logic pick_none;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/o1rq_ctrl.sv
// ----------------------------------------------------------------------------
// O(1) run queue controller
// Sequences inserts and reschedules through the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none
module o1rq_ctrl
    import o1rq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_resched) begin
                        n_state = S_RS1;
                    end else if (i_stat.in_ins_ok) begin
                        n_state = S_INS1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INS1: begin
                o_cmd.ins_append = 1'b1;
                n_state = S_INS2;
            end
            S_INS2: begin
                o_cmd.ins_link = 1'b1;
                n_state = S_DONE;
            end
            S_RS1: begin
                o_cmd.rs_append = 1'b1;
                n_state = S_RS2;
            end
            S_RS2: begin
                o_cmd.rs_pick = 1'b1;
                n_state = i_stat.pick_none ? S_DONE : S_RS3;
            end
            S_RS3: begin
                o_cmd.rs_take = 1'b1;
                n_state = S_RS4;
            end
            S_RS4: begin
                o_cmd.rs_head = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: rtl/o1rq_dpath.sv
// ----------------------------------------------------------------------------
// O(1) run queue datapath
// Thread and level tables, occupancy bitmaps, running state and result word.
// ----------------------------------------------------------------------------
`default_nettype none
module o1rq_dpath
    import o1rq_pkg::*;
#(
    parameter int MAX_THREADS     = 64,
    parameter int PRIORITY_LEVELS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_command,
    input  wire  [5:0] i_thread_id,
    input  wire        i_is_new,
    input  wire  [1:0] i_class_priority,
    input  wire  [1:0] i_thread_priority,
    input  wire        i_slice_used,
    input  wire        i_still_ready,
    input  wire        i_cfg_valid,
    input  wire  [4:0] i_cfg_pen_limit,
    input  wire        i_out_ready,
    output logic       o_out_valid,
    output logic [5:0] o_next_thread,
    output logic       o_next_idle,
    output logic       o_preempt,
    output logic [6:0] o_ready_count,
    input  t_cmd       i_cmd,
    output t_stat      o_stat
);

    localparam int TW = $clog2(MAX_THREADS);
    localparam int PW = $clog2(PRIORITY_LEVELS);
    localparam int SW = PW + 1;
    localparam int SD = 2 ** SW;

    // Tables.
    logic [PW-1:0] m_cur  [MAX_THREADS];
    logic [PW-1:0] m_max  [MAX_THREADS];
    logic [TW-1:0] m_link [MAX_THREADS];
    logic [TW-1:0] m_head [SD];
    logic [TW-1:0] m_tail [SD];

    logic [4:0]                 r_pen;
    logic                       r_act;
    logic [TW-1:0]              r_run;
    logic                       r_idle;
    logic [6:0]                 r_total;
    logic [PRIORITY_LEVELS-1:0] r_occ [2];

    logic [TW-1:0] r_tid;
    logic          r_new;
    logic [PW-1:0] r_p;
    logic          r_slice;
    logic          r_still;
    logic          r_preempt;

    logic [PW-1:0] r_cur_a, r_cur_b, r_max_b;
    logic [TW-1:0] r_tail_rd, r_head_rd, r_link_rd;
    logic [TW-1:0] r_app_t;
    logic          r_link_pend;
    logic [SW-1:0] r_pslot;
    logic          r_same;

    logic          r_out_valid;
    logic [5:0]    r_out_thread;
    logic          r_out_idle;
    logic          r_out_preempt;
    logic [6:0]    r_out_count;

    // Input decode.
    logic [15:0]   w_tid16;
    logic [TW-1:0] w_tid;
    logic [6:0]    w_p7, w_psat;
    logic [PW-1:0] w_p;
    logic [15:0]   w_run16;

    assign w_tid16 = 16'(i_thread_id);
    assign w_tid   = w_tid16[TW-1:0];
    assign w_p7    = 7'd3 + {2'b0, i_class_priority, 3'b0} + {4'b0, i_thread_priority, 1'b0};
    assign w_psat  = (w_p7 > 7'(PRIORITY_LEVELS - 1)) ? 7'(PRIORITY_LEVELS - 1) : w_p7;
    assign w_p     = w_psat[PW-1:0];
    assign w_run16 = 16'(r_run);

    assign o_stat.in_ins_ok  = (i_command == CMD_INSERT) &&
                               (32'(i_thread_id) < 32'(MAX_THREADS));
    assign o_stat.in_resched = (i_command == CMD_RESCHED);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Bonus or penalty for the running thread.
    logic signed [PW+1:0] w_diff;
    logic [PW-1:0]        w_newcur;

    assign w_diff = $signed({2'b0, r_max_b}) - $signed({2'b0, r_cur_b});

    always_comb begin
        w_newcur = r_cur_b;
        if (!r_slice) begin
            if (r_cur_b < r_max_b) begin
                w_newcur = r_cur_b + 1'b1;
            end
        end else if ((r_cur_b != '0) && (w_diff < $signed((PW + 2)'(r_pen)))) begin
            w_newcur = r_cur_b - 1'b1;
        end
    end

    // Append to a level FIFO, shared by insert and requeue.
    logic          w_app_en;
    logic          w_app_q;
    logic [PW-1:0] w_app_lvl;
    logic [TW-1:0] w_app_t;
    logic [SW-1:0] w_app_slot;
    logic          w_app_occ;
    logic [PW-1:0] w_runcur;

    always_comb begin
        w_app_en  = 1'b0;
        w_app_q   = r_act;
        w_app_lvl = r_new ? r_p : r_cur_a;
        w_app_t   = r_tid;
        if (i_cmd.ins_append) begin
            w_app_en = 1'b1;
        end else if (i_cmd.rs_append) begin
            w_app_en  = !r_idle && r_still;
            w_app_q   = !r_act;
            w_app_lvl = w_newcur;
            w_app_t   = r_run;
        end
    end

    assign w_app_slot = {w_app_q, w_app_lvl};
    assign w_app_occ  = r_occ[w_app_q][w_app_lvl];
    assign w_runcur   = (r_new && (r_tid == r_run)) ? r_p : r_cur_b;

    // Pick: swap when active is empty, then take the highest occupied level.
    logic                       w_pick_q;
    logic [PRIORITY_LEVELS-1:0] w_pick_occ;
    logic [PW-1:0]              w_pick_lvl;
    logic [SW-1:0]              w_pick_slot;

    always_comb begin
        w_pick_q = r_act;
        if (r_occ[r_act] == '0) begin
            w_pick_q = !r_act;
        end
        w_pick_occ = r_occ[w_pick_q];
        w_pick_lvl = '0;
        for (int i = 1; i < PRIORITY_LEVELS; i++) begin
            if (w_pick_occ[i]) begin
                w_pick_lvl = PW'(i);
            end
        end
    end

    assign w_pick_slot      = {w_pick_q, w_pick_lvl};
    assign o_stat.pick_none = (r_occ[0] == '0) && (r_occ[1] == '0);

    // Per-thread tables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_a <= m_cur[w_tid];
            r_cur_b <= m_cur[r_run];
            r_max_b <= m_max[r_run];
        end
        if (i_cmd.accept && o_stat.in_ins_ok && i_is_new) begin
            m_cur[w_tid] <= w_p;
            m_max[w_tid] <= w_p;
        end else if (i_cmd.rs_append && !r_idle) begin
            m_cur[r_run] <= w_newcur;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.ins_link || i_cmd.rs_pick) && r_link_pend) begin
            m_link[r_tail_rd] <= r_app_t;
        end
        if (i_cmd.rs_take) begin
            r_link_rd <= m_link[r_head_rd];
        end
    end

    // Per-level head and tail tables.
    always_ff @(posedge i_clk) begin
        if (w_app_en) begin
            r_tail_rd <= m_tail[w_app_slot];
            m_tail[w_app_slot] <= w_app_t;
        end else if (i_cmd.rs_pick) begin
            r_tail_rd <= m_tail[w_pick_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rs_pick) begin
            r_head_rd <= m_head[w_pick_slot];
        end
        if (w_app_en && !w_app_occ) begin
            m_head[w_app_slot] <= w_app_t;
        end else if (i_cmd.rs_head && !r_same) begin
            m_head[r_pslot] <= r_link_rd;
        end
    end

    // Payload and step registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tid   <= w_tid;
            r_new   <= i_is_new;
            r_p     <= w_p;
            r_slice <= i_slice_used;
            r_still <= i_still_ready;
        end
        if (w_app_en) begin
            r_app_t <= w_app_t;
        end
        if (i_cmd.rs_pick) begin
            r_pslot <= w_pick_slot;
        end
        if (i_cmd.rs_take) begin
            r_same <= (r_head_rd == r_tail_rd);
        end
        if (i_cmd.load_out) begin
            r_out_thread  <= r_idle ? 6'd0 : w_run16[5:0];
            r_out_idle    <= r_idle;
            r_out_preempt <= r_preempt;
            r_out_count   <= r_total;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen       <= 5'd5;
            r_act       <= 1'b0;
            r_run       <= '0;
            r_idle      <= 1'b1;
            r_total     <= '0;
            r_occ[0]    <= '0;
            r_occ[1]    <= '0;
            r_preempt   <= 1'b0;
            r_link_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pen <= i_cfg_pen_limit;
            end
            if (i_cmd.accept) begin
                r_preempt   <= 1'b0;
                r_link_pend <= 1'b0;
            end
            if (w_app_en) begin
                r_occ[w_app_q][w_app_lvl] <= 1'b1;
                r_link_pend <= w_app_occ;
            end
            if (i_cmd.ins_append) begin
                r_preempt <= r_idle || (w_app_lvl > w_runcur);
                if (r_total != 7'd127) begin
                    r_total <= r_total + 7'd1;
                end
            end
            if (i_cmd.rs_append && !r_idle && !r_still && (r_total != 7'd0)) begin
                r_total <= r_total - 7'd1;
            end
            if (i_cmd.rs_pick) begin
                if (o_stat.pick_none) begin
                    r_idle <= 1'b1;
                end else begin
                    r_act <= w_pick_q;
                end
            end
            if (i_cmd.rs_take) begin
                r_run  <= r_head_rd;
                r_idle <= 1'b0;
                if (r_head_rd == r_tail_rd) begin
                    r_occ[r_pslot[SW-1]][r_pslot[PW-1:0]] <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_thread = r_out_thread;
    assign o_next_idle   = r_out_idle;
    assign o_preempt     = r_out_preempt;
    assign o_ready_count = r_out_count;

endmodule
`default_nettype wire

// File: rtl/o1_priority_run_queue.sv
// A result word is loaded from the done state once the output register is free. An
// insert steps through append and link, an out-of-range insert goes to done at once,
// and a reschedule through append, pick, take and head, or ends at pick if none runs.
// No command is taken before the word is loaded; the table reads are registered.
// Reset is synchronous and active low; it empties both queues, makes the idle
// thread run and sets the penalty limit to 5.
// ----------------------------------------------------------------------------
// O(1) priority run queue
// Single-CPU active/expired run queue with per-level thread FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "o1_priority_run_queue_assert.svh"
module o1_priority_run_queue
    import o1rq_pkg::*;
#(
    parameter int MAX_THREADS     = 64,
    parameter int PRIORITY_LEVELS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Command channel.
    input  wire        i_valid,
    output logic       o_ready,
    input  wire        i_command,
    input  wire  [5:0] i_thread_id,
    input  wire        i_is_new,
    input  wire  [1:0] i_class_priority,
    input  wire  [1:0] i_thread_priority,
    input  wire        i_slice_used,
    input  wire        i_still_ready,
    // Configuration channel; the register is only written while the block is idle.
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [4:0] i_cfg_pen_limit,
    // Result channel.
    output logic       o_valid,
    input  wire        i_ready,
    output logic [5:0] o_next_thread,
    output logic       o_next_idle,
    output logic       o_preempt,
    output logic [6:0] o_ready_count
);

    // The controller walks each command through its table steps; the datapath
    // owns every table and the result register, so a finished word can wait
    // for the consumer while the next command is already accepted.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The penalty limit is taken only while no command is being worked on.
    assign o_cfg_ready = o_ready;

    o1rq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    o1rq_dpath #(
        .MAX_THREADS     (MAX_THREADS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_command         (i_command),
        .i_thread_id       (i_thread_id),
        .i_is_new          (i_is_new),
        .i_class_priority  (i_class_priority),
        .i_thread_priority (i_thread_priority),
        .i_slice_used      (i_slice_used),
        .i_still_ready     (i_still_ready),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_pen_limit   (i_cfg_pen_limit),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_next_thread     (o_next_thread),
        .o_next_idle       (o_next_idle),
        .o_preempt         (o_preempt),
        .o_ready_count     (o_ready_count),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat)
    );

    // After a command is taken the controller is busy with it.
    `O1RQ_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // A result is only loaded while the controller is busy.
    `O1RQ_ASSERT_NOW(a_load_when_busy, w_cmd.load_out, !o_ready)
    // An idle result never names a thread.
    `O1RQ_ASSERT_NOW(a_idle_thread_zero, o_valid && o_next_idle, o_next_thread == 6'd0)

endmodule
`default_nettype wire
